/* rtl/core/klex_pkg.sv */
package klex_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned NUM_W     = 31;
  localparam int unsigned CHARS_W   = 64;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned KIND_W    = 4;
  localparam int unsigned HOLD_MAX  = 8;
  localparam int unsigned MAX_IDENT_CHARS_DEFAULT = 8;

  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    TOK_END     = 4'd0,
    TOK_KW_IF   = 4'd1,
    TOK_KW_THEN = 4'd2,
    TOK_KW_ELSE = 4'd3,
    TOK_KW_FOR  = 4'd4,
    TOK_KW_IN   = 4'd5,
    TOK_IDENT   = 4'd6,
    TOK_NUMBER  = 4'd7,
    TOK_OPER    = 4'd8,
    TOK_ASSIGN  = 4'd9,
    TOK_SYMBOL  = 4'd10
  } tok_kind_t;

  // Keywords packed first character in the low byte
  localparam logic [CHARS_W-1:0] KW_IF   = 64'h0000_0000_0000_6669;
  localparam logic [CHARS_W-1:0] KW_THEN = 64'h0000_0000_6e65_6874;
  localparam logic [CHARS_W-1:0] KW_ELSE = 64'h0000_0000_6573_6c65;
  localparam logic [CHARS_W-1:0] KW_FOR  = 64'h0000_0000_0072_6f66;
  localparam logic [CHARS_W-1:0] KW_IN   = 64'h0000_0000_0000_6e69;

  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_EQUALS = 8'h3d;

  typedef struct packed {
    tok_kind_t          token_kind;
    logic [NUM_W-1:0]   number_value;
    logic [CHAR_W-1:0]  symbol;
    logic [CHARS_W-1:0] ident_chars;
    logic [LEN_W-1:0]   ident_length;
    logic               overflow;
    logic               last;
  } result_t;

endpackage

/* rtl/core/klex_char_if.sv */
interface klex_char_if;
  logic                         valid;
  logic                         ready;
  logic [klex_pkg::CHAR_W-1:0]  char_code;
  logic                         end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

/* rtl/core/klex_token_if.sv */
interface klex_token_if;
  logic                          valid;
  logic                          ready;
  logic [klex_pkg::KIND_W-1:0]   token_kind;
  logic [klex_pkg::NUM_W-1:0]    number_value;
  logic [klex_pkg::CHAR_W-1:0]   symbol;
  logic [klex_pkg::CHARS_W-1:0]  ident_chars;
  logic [klex_pkg::LEN_W-1:0]    ident_length;
  logic                          overflow;
  logic                          last;

  modport source (output valid, output token_kind, output number_value, output symbol,
                  output ident_chars, output ident_length, output overflow,
                  output last, input ready);
  modport sink   (input valid, input token_kind, input number_value, input symbol,
                  input ident_chars, input ident_length, input overflow,
                  input last, output ready);
endinterface

/* rtl/core/keyword_identifier_number_lexer.sv */
// Byte-stream lexer: takes one ASCII byte (or an end-of-input mark) per transfer on
// char_in and gives tokens on token_out: keywords if/then/else/for/in, identifiers
// (first MAX_IDENT_CHARS characters, overflow when longer), saturating decimal numbers,
// operator '+'/'-', assign '=', any other non-blank byte as a symbol, and an end token.
// Identifier and number tokens leave only when the byte after them arrives, so a
// byte may cause zero, one or two tokens; 'last' flags the final token of each byte.
// Rate: one byte per clock cycle while the result queue has room. Each byte is
// classified and the run state updated in the cycle it is taken; its tokens are written
// to the three-entry result queue, whose head drives token_out. char_in is ready while
// that queue holds at most one token, so a byte giving two tokens stalls char_in behind
// the single token_out port; with token_out always ready that is the only stall.
module keyword_identifier_number_lexer #(
  parameter int unsigned MAX_IDENT_CHARS = klex_pkg::MAX_IDENT_CHARS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  klex_char_if.sink           char_in,
  klex_token_if.source        token_out
);

  localparam logic [klex_pkg::LEN_W-1:0] MAX_LEN  = klex_pkg::LEN_W'(MAX_IDENT_CHARS);
  localparam logic [klex_pkg::LEN_W-1:0] HOLD_LEN = klex_pkg::LEN_W'(klex_pkg::HOLD_MAX);
  localparam int unsigned QDEPTH = 3;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_IDENT  = 3'b010,
    MODE_NUMBER = 3'b100
  } mode_t;

  // run state
  mode_t                           scan_mode, scan_mode_next;
  logic [klex_pkg::CHARS_W-1:0]    ident_buffer, ident_buffer_next;
  logic [klex_pkg::LEN_W-1:0]      ident_count, ident_count_next;
  logic                            ident_truncated, ident_truncated_next;
  logic [klex_pkg::NUM_W-1:0]      number_accumulator, number_accumulator_next;
  logic                            number_saturated, number_saturated_next;

  // result queue, head at entry 0
  klex_pkg::result_t               queue [QDEPTH];
  klex_pkg::result_t               queue_next [QDEPTH];
  logic [1:0]                      queue_count, queue_count_next;

  logic                            in_fire, out_fire;
  logic [klex_pkg::CHAR_W-1:0]     c;
  logic                            is_space, is_alpha, is_digit;
  logic [klex_pkg::NUM_W+3:0]      digit_sum;
  logic [klex_pkg::LEN_W-1:0]      shown;
  klex_pkg::tok_kind_t             kw_kind;
  klex_pkg::result_t               flush_tok, second_tok, res_a, res_b;
  logic                            flush_now, flush_valid, second_valid;
  logic [1:0]                      n_res;
  logic [1:0]                      base;

  assign c        = char_in.char_code;
  assign in_fire  = char_in.valid && char_in.ready;
  assign out_fire = token_out.valid && token_out.ready;

  // Hold input while the queue could not take two more tokens
  assign char_in.ready = (queue_count < 2'd2);

  assign is_space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  assign is_alpha = (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  assign is_digit = (c >= 8'd48 && c <= 8'd57);

  // acc * 10 + digit; a digit byte's value is its low nibble
  assign digit_sum = {1'b0, number_accumulator, 3'b000}
                   + {3'b000, number_accumulator, 1'b0}
                   + (klex_pkg::NUM_W+4)'(c[3:0]);

  // Keyword match on the full held word; a truncated run is never a keyword
  always_comb begin
    kw_kind = klex_pkg::TOK_IDENT;
    if (!ident_truncated) begin
      if (ident_count == 4'd2 && ident_buffer == klex_pkg::KW_IF) begin
        kw_kind = klex_pkg::TOK_KW_IF;
      end else if (ident_count == 4'd4 && ident_buffer == klex_pkg::KW_THEN) begin
        kw_kind = klex_pkg::TOK_KW_THEN;
      end else if (ident_count == 4'd4 && ident_buffer == klex_pkg::KW_ELSE) begin
        kw_kind = klex_pkg::TOK_KW_ELSE;
      end else if (ident_count == 4'd3 && ident_buffer == klex_pkg::KW_FOR) begin
        kw_kind = klex_pkg::TOK_KW_FOR;
      end else if (ident_count == 4'd2 && ident_buffer == klex_pkg::KW_IN) begin
        kw_kind = klex_pkg::TOK_KW_IN;
      end
    end
  end

  assign shown = (ident_count > MAX_LEN) ? MAX_LEN : ident_count;

  // Token for the run in progress, if it were closed now
  always_comb begin
    flush_tok = '0;
    unique case (scan_mode)
      MODE_IDENT: begin
        flush_tok.token_kind = kw_kind;
        if (kw_kind == klex_pkg::TOK_IDENT) begin
          for (int i = 0; i < 8; i++) begin
            if (klex_pkg::LEN_W'(i) < shown) begin
              flush_tok.ident_chars[8*i +: 8] = ident_buffer[8*i +: 8];
            end
          end
          flush_tok.ident_length = shown;
          flush_tok.overflow     = ident_truncated || (ident_count > MAX_LEN);
        end
      end
      MODE_NUMBER: begin
        flush_tok.token_kind   = klex_pkg::TOK_NUMBER;
        flush_tok.number_value = number_accumulator;
        flush_tok.overflow     = number_saturated;
      end
      MODE_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  // Step the run state for one byte and pick the token it causes after any flush
  always_comb begin
    scan_mode_next          = scan_mode;
    ident_buffer_next       = ident_buffer;
    ident_count_next        = ident_count;
    ident_truncated_next    = ident_truncated;
    number_accumulator_next = number_accumulator;
    number_saturated_next   = number_saturated;
    flush_now               = 1'b0;
    second_valid            = 1'b0;
    second_tok              = '0;

    if (char_in.end_of_input) begin
      flush_now = 1'b1;
      second_valid = 1'b1;
      second_tok.token_kind = klex_pkg::TOK_END;
    end else if (scan_mode == MODE_IDENT && (is_alpha || is_digit)) begin
      if (ident_count < HOLD_LEN) begin
        for (int i = 0; i < 8; i++) begin
          if (ident_count == klex_pkg::LEN_W'(i)) begin
            ident_buffer_next[8*i +: 8] = c;
          end
        end
        ident_count_next = ident_count + 4'd1;
      end else begin
        ident_truncated_next = 1'b1;
      end
    end else if (scan_mode == MODE_NUMBER && is_digit) begin
      if (digit_sum > (klex_pkg::NUM_W+4)'(klex_pkg::NUM_MAX)) begin
        number_accumulator_next = klex_pkg::NUM_MAX;
        number_saturated_next   = 1'b1;
      end else begin
        number_accumulator_next = digit_sum[klex_pkg::NUM_W-1:0];
      end
    end else begin
      flush_now = 1'b1;
      if (is_space) begin
        // skip blanks between tokens
      end else if (is_alpha) begin
        second_valid = 1'b0;
      end else if (is_digit) begin
        second_valid = 1'b0;
      end else begin
        second_valid      = 1'b1;
        second_tok.symbol = c;
        if (c == klex_pkg::CH_PLUS || c == klex_pkg::CH_MINUS) begin
          second_tok.token_kind = klex_pkg::TOK_OPER;
        end else if (c == klex_pkg::CH_EQUALS) begin
          second_tok.token_kind = klex_pkg::TOK_ASSIGN;
        end else begin
          second_tok.token_kind = klex_pkg::TOK_SYMBOL;
        end
      end
    end

    // Closing a run clears the run state; a letter or digit opens a fresh one
    if (flush_now) begin
      scan_mode_next          = MODE_IDLE;
      ident_buffer_next       = '0;
      ident_count_next        = '0;
      ident_truncated_next    = 1'b0;
      number_accumulator_next = '0;
      number_saturated_next   = 1'b0;
      if (!char_in.end_of_input && is_alpha) begin
        scan_mode_next                 = MODE_IDENT;
        ident_buffer_next[7:0]         = c;
        ident_count_next               = 4'd1;
      end else if (!char_in.end_of_input && is_digit) begin
        scan_mode_next          = MODE_NUMBER;
        number_accumulator_next = klex_pkg::NUM_W'(c[3:0]);
      end
    end
  end

  assign flush_valid = flush_now && (scan_mode != MODE_IDLE);
  assign n_res       = {1'b0, flush_valid} + {1'b0, second_valid};

  always_comb begin
    res_a      = flush_valid ? flush_tok : second_tok;
    res_a.last = !(flush_valid && second_valid);
    res_b      = second_tok;
    res_b.last = 1'b1;
  end

  // Advance the queue on an output transfer, then append this byte's tokens
  assign base = queue_count - {1'b0, out_fire};

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      if (out_fire && i < QDEPTH - 1) begin
        queue_next[i] = queue[(i + 1) % QDEPTH];
      end else begin
        queue_next[i] = queue[i];
      end
      if (in_fire && n_res != 2'd0 && base == 2'(i)) begin
        queue_next[i] = res_a;
      end
      if (in_fire && n_res == 2'd2 && (base + 2'd1) == 2'(i)) begin
        queue_next[i] = res_b;
      end
    end
  end

  assign queue_count_next = base + (in_fire ? n_res : 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode          <= MODE_IDLE;
      ident_buffer       <= '0;
      ident_count        <= '0;
      ident_truncated    <= 1'b0;
      number_accumulator <= '0;
      number_saturated   <= 1'b0;
      queue_count        <= '0;
    end else begin
      queue_count <= queue_count_next;
      if (in_fire) begin
        scan_mode          <= scan_mode_next;
        ident_buffer       <= ident_buffer_next;
        ident_count        <= ident_count_next;
        ident_truncated    <= ident_truncated_next;
        number_accumulator <= number_accumulator_next;
        number_saturated   <= number_saturated_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      queue[i] <= queue_next[i];
    end
  end

  // Present the queue head
  assign token_out.valid        = (queue_count != 2'd0);
  assign token_out.token_kind   = queue[0].token_kind;
  assign token_out.number_value = queue[0].number_value;
  assign token_out.symbol       = queue[0].symbol;
  assign token_out.ident_chars  = queue[0].ident_chars;
  assign token_out.ident_length = queue[0].ident_length;
  assign token_out.overflow     = queue[0].overflow;
  assign token_out.last         = queue[0].last;

  // An end mark always leaves a token behind and the lexer idle
  a_end_gives_token: assert property (@(posedge clk) disable iff (rst)
    (in_fire && char_in.end_of_input) |=> (token_out.valid && scan_mode == MODE_IDLE))
    else $error("end mark did not leave a token and an idle lexer");

  // Input must be held while the queue lacks room for two tokens
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    (queue_count >= 2'd2) |-> !char_in.ready)
    else $error("input taken without room for two tokens");

  // Only number tokens carry a value
  a_number_only: assert property (@(posedge clk) disable iff (rst)
    (token_out.valid && token_out.token_kind != klex_pkg::TOK_NUMBER)
      |-> (token_out.number_value == '0))
    else $error("non-number token carries a value");

  // Identifier length never exceeds the configured limit
  a_ident_len: assert property (@(posedge clk) disable iff (rst)
    token_out.valid |-> (token_out.ident_length <= MAX_LEN))
    else $error("identifier length beyond limit");

endmodule
